FILE: design/fyts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fyts_pkg
// Shared types and constants for the Fisher-Yates tile shuffler.
// ----------------------------------------------------------------------------
package fyts_pkg;

    localparam int MAX_TILES_DEFAULT = 64;

    // Fixed field widths
    localparam int GROUP_W   = 3;
    localparam int VALUE_W   = 5;
    localparam int TILE_W    = GROUP_W + VALUE_W;
    localparam int RND_W     = 31;
    localparam int IDX_W     = 6;
    localparam int SZ_W      = 7;
    localparam int OP_W      = 2;
    localparam int STS_W     = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [SZ_W-1:0] DECK_SIZE_RESET = 7'd50;
    localparam logic [SZ_W-1:0] SIZE_MIN        = 7'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_SHUFFLE = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } fyts_op_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_DONE  = 2'd1,
        STS_FULL  = 2'd2,
        STS_RANGE = 2'd3
    } fyts_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_WAIT,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_RD_WAIT,
        ST_RESULT
    } fyts_state_t;

endpackage

FILE: design/fyts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fyts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fyts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/fyts_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fyts_mod
// Restoring bit-serial remainder unit: dividend mod divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module fyts_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fyts_pkg::RND_W-1:0] dividend,
    input  logic [fyts_pkg::SZ_W-1:0]  divisor,
    output logic                      done,
    output logic [fyts_pkg::SZ_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(fyts_pkg::RND_W);
    localparam int SZ_W  = fyts_pkg::SZ_W;

    logic [fyts_pkg::RND_W-1:0] dvd_reg;
    logic [SZ_W-1:0]            dsr_reg;
    logic [SZ_W-1:0]            rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [SZ_W:0]              trial;

    // remainder stays below the divisor, so the shifted trial fits SZ_W+1 bits
    assign trial = {rem_reg, dvd_reg[fyts_pkg::RND_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(fyts_pkg::RND_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= SZ_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= trial[SZ_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/fisher_yates_tile_shuffler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisher_yates_tile_shuffler
// Tile deck in a RAM with load, Fisher-Yates shuffle step, read and restart.
// ----------------------------------------------------------------------------
// Load, restart and flagged items go from EXEC straight to RESULT; a read passes
// through RD_WAIT, and a shuffle step through DIV_WAIT, RD_I, RD_J, WR_I and WR_J.
// The shuffle step runs the bit-serial modulo unit, then two
// reads and two writes on the single-read, single-write deck RAM.
// One item is in flight at a time; the next is taken in IDLE, after the result
// is registered. Reset clears control state only.
module fisher_yates_tile_shuffler #(
    parameter int MAX_TILES = fyts_pkg::MAX_TILES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_axis_tdata: tile_group[2:0], tile_value[7:3], random_word[38:8],
    //               read_index[44:39], zero pad[47:45]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fyts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: opcode[1:0]
    input  logic [fyts_pkg::OP_W-1:0]        s_axis_tuser,
    // m_axis_tdata: tile[7:0], swap_partner[13:8], status[15:14]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fyts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // deck_size register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fyts_pkg::SZ_W-1:0]        cfg_data
);

    localparam int AW     = $clog2(MAX_TILES);
    localparam int SZ_W   = fyts_pkg::SZ_W;
    localparam int TILE_W = fyts_pkg::TILE_W;
    localparam int IDX_W  = fyts_pkg::IDX_W;
    localparam int CLAMP  = (MAX_TILES > 127) ? 127 : MAX_TILES;
    localparam logic [SZ_W-1:0] SIZE_MAX = SZ_W'(CLAMP);

    function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] raw);
        logic [SZ_W-1:0] s;
        s = raw;
        if (s < fyts_pkg::SIZE_MIN)
        begin
            s = fyts_pkg::SIZE_MIN;
        end
        if (s > SIZE_MAX)
        begin
            s = SIZE_MAX;
        end
        return s;
    endfunction

    localparam logic [SZ_W-1:0] POS_RESET = eff_size(fyts_pkg::DECK_SIZE_RESET) - 7'd1;

    fyts_pkg::fyts_state_t state_reg, state_next;

    logic [SZ_W-1:0]                deck_size_reg;
    logic [SZ_W-1:0]                lp_reg;
    logic [SZ_W-1:0]                pos_reg;
    logic [SZ_W-1:0]                j_reg;
    fyts_pkg::fyts_op_t             op_reg;
    logic [fyts_pkg::GROUP_W-1:0]   group_reg;
    logic [fyts_pkg::VALUE_W-1:0]   value_reg;
    logic [fyts_pkg::RND_W-1:0]     rnd_reg;
    logic [IDX_W-1:0]               ridx_reg;
    logic [TILE_W-1:0]              tile_a_reg;
    logic [TILE_W-1:0]              res_tile_reg;
    logic [IDX_W-1:0]               res_partner_reg;
    fyts_pkg::fyts_status_t         res_status_reg;
    logic                           out_valid_reg;
    logic [fyts_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [SZ_W-1:0]   size;
    logic              in_fire;
    logic              cfg_fire;
    logic              out_free;
    logic              load_ok;
    logic              shuf_ok;
    logic              read_ok;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [TILE_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [TILE_W-1:0] mem_rdata;

    logic              div_start;
    logic              div_done;
    logic [SZ_W-1:0]   div_rem;

    assign size     = eff_size(deck_size_reg);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load_ok  = lp_reg < size;
    assign shuf_ok  = (pos_reg != '0) && (pos_reg < size);
    assign read_ok  = {1'b0, ridx_reg} < size;

    assign cfg_ready = 1'b1;

    fyts_ram #(
        .WIDTH (TILE_W),
        .DEPTH (MAX_TILES)
    ) u_deck (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fyts_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (pos_reg + 7'd1),
        .done      (div_done),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fyts_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = fyts_pkg::ST_EXEC;
                end
            end
            fyts_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    fyts_pkg::OP_SHUFFLE:
                        state_next = shuf_ok ? fyts_pkg::ST_DIV_WAIT : fyts_pkg::ST_RESULT;
                    fyts_pkg::OP_READ:
                        state_next = read_ok ? fyts_pkg::ST_RD_WAIT : fyts_pkg::ST_RESULT;
                    default:
                        state_next = fyts_pkg::ST_RESULT;
                endcase
            end
            fyts_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = fyts_pkg::ST_RD_I;
                end
            end
            fyts_pkg::ST_RD_I:    state_next = fyts_pkg::ST_RD_J;
            fyts_pkg::ST_RD_J:    state_next = fyts_pkg::ST_WR_I;
            fyts_pkg::ST_WR_I:    state_next = fyts_pkg::ST_WR_J;
            fyts_pkg::ST_WR_J:    state_next = fyts_pkg::ST_RESULT;
            fyts_pkg::ST_RD_WAIT: state_next = fyts_pkg::ST_RESULT;
            fyts_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = fyts_pkg::ST_IDLE;
                end
            end
            default:              state_next = fyts_pkg::ST_IDLE;
        endcase
    end

    // control outputs: RAM ports, modulo start, input ready
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = AW'(lp_reg);
        mem_wdata     = {group_reg, value_reg};
        mem_raddr     = AW'(ridx_reg);
        div_start     = 1'b0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            fyts_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            fyts_pkg::ST_EXEC:
            begin
                if (op_reg == fyts_pkg::OP_LOAD && load_ok)
                begin
                    mem_we = 1'b1;
                end
                if (op_reg == fyts_pkg::OP_SHUFFLE && shuf_ok)
                begin
                    div_start = 1'b1;
                end
            end
            fyts_pkg::ST_RD_I:
            begin
                mem_raddr = AW'(pos_reg);
            end
            fyts_pkg::ST_RD_J:
            begin
                mem_raddr = AW'(j_reg);
            end
            fyts_pkg::ST_WR_I:
            begin
                // entry j lands in slot i
                mem_we    = 1'b1;
                mem_waddr = AW'(pos_reg);
                mem_wdata = mem_rdata;
            end
            fyts_pkg::ST_WR_J:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(j_reg);
                mem_wdata = tile_a_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fyts_pkg::ST_IDLE;
            deck_size_reg <= fyts_pkg::DECK_SIZE_RESET;
            lp_reg        <= '0;
            pos_reg       <= POS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                deck_size_reg <= cfg_data;
                lp_reg        <= '0;
                pos_reg       <= eff_size(cfg_data) - 7'd1;
            end
            else if (state_reg == fyts_pkg::ST_EXEC)
            begin
                if (op_reg == fyts_pkg::OP_LOAD && load_ok)
                begin
                    lp_reg <= lp_reg + 7'd1;
                end
                else if (op_reg == fyts_pkg::OP_RESTART)
                begin
                    lp_reg  <= '0;
                    pos_reg <= size - 7'd1;
                end
            end
            else if (state_reg == fyts_pkg::ST_WR_J)
            begin
                pos_reg <= pos_reg - 7'd1;
            end

            if (state_reg == fyts_pkg::ST_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= fyts_pkg::fyts_op_t'(s_axis_tuser);
            group_reg <= s_axis_tdata[2:0];
            value_reg <= s_axis_tdata[7:3];
            rnd_reg   <= s_axis_tdata[38:8];
            ridx_reg  <= s_axis_tdata[44:39];
        end

        unique case (state_reg)
            fyts_pkg::ST_EXEC:
            begin
                res_tile_reg    <= '0;
                res_partner_reg <= '0;
                res_status_reg  <= fyts_pkg::STS_OK;
                unique case (op_reg)
                    fyts_pkg::OP_LOAD:
                    begin
                        if (load_ok)
                        begin
                            res_tile_reg <= {group_reg, value_reg};
                        end
                        else
                        begin
                            res_status_reg <= fyts_pkg::STS_FULL;
                        end
                    end
                    fyts_pkg::OP_SHUFFLE:
                    begin
                        if (!shuf_ok)
                        begin
                            res_status_reg <= fyts_pkg::STS_DONE;
                        end
                    end
                    fyts_pkg::OP_READ:
                    begin
                        if (!read_ok)
                        begin
                            res_status_reg <= fyts_pkg::STS_RANGE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            fyts_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    j_reg <= div_rem;
                end
            end
            fyts_pkg::ST_RD_J:
            begin
                tile_a_reg <= mem_rdata;
            end
            fyts_pkg::ST_WR_I:
            begin
                res_tile_reg    <= mem_rdata;
                res_partner_reg <= IDX_W'(j_reg);
            end
            fyts_pkg::ST_RD_WAIT:
            begin
                res_tile_reg <= mem_rdata;
            end
            default:
            begin
            end
        endcase

        if (state_reg == fyts_pkg::ST_RESULT && out_free)
        begin
            out_data_reg <= {res_status_reg, res_partner_reg, res_tile_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // shuffle position always stays inside the deck
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg < size)
        else $error("shuffle position outside deck");

    assert property (@(posedge clk) disable iff (!rst_n) lp_reg <= size)
        else $error("load pointer past deck size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fyts_pkg::ST_IDLE) |-> !mem_we)
        else $error("deck write while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == fyts_pkg::ST_DIV_WAIT))
        else $error("modulo result outside wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fyts_pkg::ST_WR_J) |-> (j_reg <= pos_reg))
        else $error("swap partner above position");

endmodule
